// ===== sv/ussr_pkg.sv =====
package ussr_pkg;

  localparam int unsigned DelayW   = 20;
  localparam int unsigned TrigW    = 10;
  localparam int unsigned TimeoutW = 17;
  localparam int unsigned StepsW   = 12;
  localparam int unsigned IncW     = 7;
  localparam int unsigned AngleW   = 10;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DistW    = 10;
  localparam int unsigned AngOutW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // floor(x / 116) == (x * 36158) >> 22 for every 16-bit x
  localparam logic [CountW-1:0] DivRecip = 16'd36158;
  localparam int unsigned DivShift = 22;

  localparam logic [AngleW-1:0]  AngleMax    = '1;
  localparam logic [CountW-1:0]  CountMax    = '1;
  localparam logic [AngOutW-1:0] AngTimeout  = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_DELAY = 3'd0,
    CFG_SETTLE     = 3'd1,
    CFG_TRIGGER    = 3'd2,
    CFG_TIMEOUT    = 3'd3,
    CFG_GAP        = 3'd4,
    CFG_STEPS      = 3'd5,
    CFG_ANGLE_INC  = 3'd6,
    CFG_ANGLE_LIM  = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_DECIDE  = 3'd0,
    PH_STEP    = 3'd1,
    PH_SETTLE  = 3'd2,
    PH_MEASURE = 3'd3,
    PH_GAP     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CAP_WAIT_RISE = 2'd0,
    CAP_COUNTING  = 2'd1,
    CAP_DONE      = 2'd2
  } cap_t;

  // durations are stored already clamped to at least one, minus one where used so
  typedef struct packed {
    logic [DelayW-1:0]   step_m1;
    logic [DelayW-1:0]   settle_m1;
    logic [TrigW-1:0]    trig_len;
    logic [TimeoutW-1:0] timeout_m1;
    logic [DelayW-1:0]   gap_m1;
    logic [StepsW-1:0]   steps;
    logic [IncW-1:0]     angle_inc;
    logic [AngleW-1:0]   angle_lim;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         coil_pattern;
    logic               trigger_out;
    logic               report_valid;
    logic [DistW-1:0]   distance_cm;
    logic [AngOutW-1:0] angle_deg;
    logic               timed_out;
  } result_t;

endpackage

// ===== sv/ussr_in_if.sv =====
interface ussr_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

// ===== sv/ussr_out_if.sv =====
interface ussr_out_if import ussr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [3:0]         coil_pattern;
  logic               trigger_out;
  logic               report_valid;
  logic [DistW-1:0]   distance_cm;
  logic [AngOutW-1:0] angle_deg;
  logic               timed_out;

  modport source (output valid, output coil_pattern, output trigger_out, output report_valid,
                  output distance_cm, output angle_deg, output timed_out, input ready);
  modport sink (input valid, input coil_pattern, input trigger_out, input report_valid,
                input distance_cm, input angle_deg, input timed_out, output ready);
endinterface

// ===== sv/ussr_cfg_regs.sv =====
module ussr_cfg_regs import ussr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  logic [DelayW-1:0]   dly_m1;
  logic [TrigW-1:0]    trig_v;
  logic [TimeoutW-1:0] to_v;

  always_comb begin
    // zero in a duration register acts as one
    dly_m1 = (cfg_data == '0) ? '0 : cfg_data - 1'b1;
    trig_v = cfg_data[TrigW-1:0];
    if (trig_v == '0) begin
      trig_v = TrigW'(1);
    end
    to_v = cfg_data[TimeoutW-1:0];
    to_v = (to_v == '0) ? '0 : to_v - 1'b1;
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEP_DELAY: cfg_nxt.step_m1    = dly_m1;
        CFG_SETTLE:     cfg_nxt.settle_m1  = dly_m1;
        CFG_TRIGGER:    cfg_nxt.trig_len   = trig_v;
        CFG_TIMEOUT:    cfg_nxt.timeout_m1 = to_v;
        CFG_GAP:        cfg_nxt.gap_m1     = dly_m1;
        CFG_STEPS:      cfg_nxt.steps      = cfg_data[StepsW-1:0];
        CFG_ANGLE_INC:  cfg_nxt.angle_inc  = cfg_data[IncW-1:0];
        CFG_ANGLE_LIM:  cfg_nxt.angle_lim  = cfg_data[AngleW-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_m1    <= DelayW'(3999);
      cfg_r.settle_m1  <= DelayW'(99999);
      cfg_r.trig_len   <= TrigW'(20);
      cfg_r.timeout_m1 <= TimeoutW'(65535);
      cfg_r.gap_m1     <= DelayW'(199999);
      cfg_r.steps      <= StepsW'(57);
      cfg_r.angle_inc  <= IncW'(5);
      cfg_r.angle_lim  <= AngleW'(360);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/ussr_core.sv =====
module ussr_core import ussr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  logic    echo,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t              phase_r, phase_nxt;
  logic [1:0]          seq_r, seq_nxt;
  logic [StepsW-1:0]   steps_r, steps_nxt;
  logic [DelayW-1:0]   timer_r, timer_nxt;
  logic [AngleW-1:0]   angle_r, angle_nxt;
  logic                down_r, down_nxt;
  logic [CountW-1:0]   cnt_r, cnt_nxt;
  cap_t                cap_r, cap_nxt;
  logic                last_r;

  logic                rising, falling, done;
  logic [1:0]          seq_step;
  logic [CountW-1:0]   cnt_inc;
  logic [AngleW:0]     angle_sum;
  logic [2*CountW-1:0] prod;

  assign rising  = echo & ~last_r;
  assign falling = ~echo & last_r;
  assign cnt_inc = (cnt_r != CountMax) ? cnt_r + 1'b1 : cnt_r;
  assign prod    = cnt_inc * DivRecip;
  assign angle_sum = {1'b0, angle_r} + (AngleW + 1)'(cfg.angle_inc);
  assign seq_step  = down_r ? seq_r - 2'd1 : seq_r + 2'd1;

  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    steps_nxt = steps_r;
    timer_nxt = timer_r;
    angle_nxt = angle_r;
    down_nxt  = down_r;
    cnt_nxt   = cnt_r;
    cap_nxt   = cap_r;
    done      = 1'b0;
    res       = '0;
    case (phase_r)
      PH_STEP: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - 1'b1;
          res.coil_pattern = 4'b0001 << seq_r;
        end else if (steps_r != '0) begin
          seq_nxt   = seq_step;
          steps_nxt = steps_r - 1'b1;
          timer_nxt = cfg.step_m1;
          res.coil_pattern = 4'b0001 << seq_step;
        end else begin
          if (down_r) begin
            angle_nxt = (angle_r > AngleW'(cfg.angle_inc))
                        ? angle_r - AngleW'(cfg.angle_inc) : '0;
          end else begin
            angle_nxt = angle_sum[AngleW] ? AngleMax : angle_sum[AngleW-1:0];
          end
          phase_nxt = PH_SETTLE;
          timer_nxt = cfg.settle_m1;
        end
      end
      PH_SETTLE: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - 1'b1;
        end else begin
          phase_nxt = PH_MEASURE;
          timer_nxt = '0;
          cap_nxt   = CAP_WAIT_RISE;
          cnt_nxt   = '0;
        end
      end
      PH_MEASURE: begin
        res.trigger_out = (timer_r < DelayW'(cfg.trig_len));
        case (cap_r)
          CAP_WAIT_RISE: begin
            if (rising) begin
              cnt_nxt = '0;
              cap_nxt = CAP_COUNTING;
            end
          end
          CAP_COUNTING: begin
            cnt_nxt = cnt_inc;
            if (falling) begin
              cap_nxt = CAP_DONE;
              done    = 1'b1;
            end
          end
          default: cap_nxt = cap_r;
        endcase
        if (done) begin
          res.report_valid = 1'b1;
          res.distance_cm  = prod[DivShift +: DistW];
          res.angle_deg    = AngOutW'(angle_r);
        end else if (timer_r >= DelayW'(cfg.timeout_m1)) begin
          res.report_valid = 1'b1;
          res.angle_deg    = AngTimeout;
          res.timed_out    = 1'b1;
        end else begin
          timer_nxt = timer_r + 1'b1;
        end
        if (res.report_valid) begin
          phase_nxt = PH_GAP;
          timer_nxt = cfg.gap_m1;
        end
      end
      PH_GAP: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - 1'b1;
        end else begin
          phase_nxt = PH_DECIDE;
        end
      end
      default: begin
        // direction reverses at the limit and at zero
        if (angle_r >= cfg.angle_lim) begin
          angle_nxt = cfg.angle_lim;
          down_nxt  = 1'b1;
        end else if (angle_r == '0) begin
          down_nxt = 1'b0;
        end
        steps_nxt = cfg.steps;
        timer_nxt = '0;
        phase_nxt = PH_STEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DECIDE;
      seq_r   <= '0;
      steps_r <= '0;
      timer_r <= '0;
      angle_r <= '0;
      down_r  <= 1'b0;
      cnt_r   <= '0;
      cap_r   <= CAP_WAIT_RISE;
      last_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      steps_r <= steps_nxt;
      timer_r <= timer_nxt;
      angle_r <= angle_nxt;
      down_r  <= down_nxt;
      cnt_r   <= cnt_nxt;
      cap_r   <= cap_nxt;
      last_r  <= echo;
    end
  end

endmodule

// ===== sv/ultrasonic_sweep_ranger.sv =====
// Stepper-swept ultrasonic ranger. Each transfer on in_ch is one 0.5 us tick with the sampled
// echo level, and each gives exactly one transfer on out_ch with the coil drive, trigger level
// and, on report ticks, the distance (echo ticks / 116) and angle, or a timeout flag with angle
// 65535. The echo is registered, the sequencer state is advanced by combinational logic, and the
// result lands in an output register, so throughput is one tick per cycle while out_ch accepts.
// Configuration must be written through cfg_we/cfg_index/cfg_data while no ticks are in flight,
// which the block itself does not enforce; zero in a duration register acts as one.
module ultrasonic_sweep_ranger import ussr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  ussr_in_if.sink             in_ch,
  ussr_out_if.source          out_ch
);

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    in_vld_r, in_vld_nxt;
  logic    echo_r;
  logic    out_vld_r, out_vld_nxt;
  logic    advance;
  logic    in_xfer;

  ussr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ussr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .echo    (echo_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign advance     = in_vld_r & (~out_vld_r | out_ch.ready);
  assign in_ch.ready = rst_n & (~in_vld_r | advance);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign in_vld_nxt  = in_xfer | (in_vld_r & ~advance);
  assign out_vld_nxt = advance | (out_vld_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      echo_r <= in_ch.echo_level;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.coil_pattern = res_r.coil_pattern;
  assign out_ch.trigger_out  = res_r.trigger_out;
  assign out_ch.report_valid = res_r.report_valid;
  assign out_ch.distance_cm  = res_r.distance_cm;
  assign out_ch.angle_deg    = res_r.angle_deg;
  assign out_ch.timed_out    = res_r.timed_out;

endmodule

// ===== dv/tb_ultrasonic_sweep_ranger.sv =====
`timescale 1ns / 1ps

module tb_ultrasonic_sweep_ranger;
  import ussr_pkg::*;

  localparam int unsigned TicksPerCm = 116;
  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned SettleCycles = 4;

  // tracks the sweep sequencer tick by tick and holds the outputs still owed
  class sweep_ledger;
    logic [DelayW-1:0]   step_delay;
    logic [DelayW-1:0]   settle_len;
    logic [TrigW-1:0]    trig_len;
    logic [TimeoutW-1:0] timeout_len;
    logic [DelayW-1:0]   gap_len;
    logic [StepsW-1:0]   steps_per_move;
    logic [IncW-1:0]     angle_inc;
    logic [AngleW-1:0]   angle_lim;

    phase_t              phase;
    logic [1:0]          coil_idx;
    logic [StepsW-1:0]   steps_left;
    logic [DelayW-1:0]   timer;
    logic [AngleW-1:0]   angle;
    logic                sweep_down;
    logic [CountW-1:0]   echo_cnt;
    cap_t                cap;
    logic                last_echo;

    result_t             tick_outputs[$];
    int unsigned         reports;
    int unsigned         errors;

    function new();
      step_delay     = 4000;
      settle_len     = 100000;
      trig_len       = 20;
      timeout_len    = 65536;
      gap_len        = 200000;
      steps_per_move = 57;
      angle_inc      = 5;
      angle_lim      = 360;
      phase      = PH_DECIDE;
      coil_idx   = '0;
      steps_left = '0;
      timer      = '0;
      angle      = '0;
      sweep_down = 1'b0;
      echo_cnt   = '0;
      cap        = CAP_WAIT_RISE;
      last_echo  = 1'b0;
      reports    = 0;
      errors     = 0;
    endfunction

    function int unsigned min1(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CfgDataW-1:0] d);
      case (idx)
        CFG_STEP_DELAY: step_delay     = d[DelayW-1:0];
        CFG_SETTLE:     settle_len     = d[DelayW-1:0];
        CFG_TRIGGER:    trig_len       = d[TrigW-1:0];
        CFG_TIMEOUT:    timeout_len    = d[TimeoutW-1:0];
        CFG_GAP:        gap_len        = d[DelayW-1:0];
        CFG_STEPS:      steps_per_move = d[StepsW-1:0];
        CFG_ANGLE_INC:  angle_inc      = d[IncW-1:0];
        CFG_ANGLE_LIM:  angle_lim      = d[AngleW-1:0];
        default: ;
      endcase
    endfunction

    function void log_tick(logic echo);
      result_t r;
      logic rising;
      logic falling;
      logic done;
      int unsigned sum;
      r = '0;
      rising = echo && !last_echo;
      falling = !echo && last_echo;
      last_echo = echo;
      case (phase)
        PH_STEP: begin
          if (timer > 0) begin
            timer--;
            r.coil_pattern = 4'b0001 << coil_idx;
          end else if (steps_left > 0) begin
            coil_idx = sweep_down ? coil_idx - 2'd1 : coil_idx + 2'd1;
            steps_left--;
            timer = DelayW'(min1(step_delay) - 1);
            r.coil_pattern = 4'b0001 << coil_idx;
          end else begin
            if (sweep_down) begin
              angle = (angle > angle_inc) ? angle - angle_inc : '0;
            end else begin
              sum = angle + angle_inc;
              angle = (sum > AngleMax) ? AngleMax : AngleW'(sum);
            end
            phase = PH_SETTLE;
            timer = DelayW'(min1(settle_len) - 1);
          end
        end
        PH_SETTLE: begin
          if (timer > 0) begin
            timer--;
          end else begin
            phase = PH_MEASURE;
            timer = '0;
            cap = CAP_WAIT_RISE;
            echo_cnt = '0;
          end
        end
        PH_MEASURE: begin
          done = 1'b0;
          r.trigger_out = (timer < min1(trig_len));
          if (cap == CAP_WAIT_RISE) begin
            if (rising) begin
              echo_cnt = '0;
              cap = CAP_COUNTING;
            end
          end else if (cap == CAP_COUNTING) begin
            if (echo_cnt != CountMax) echo_cnt++;
            if (falling) begin
              cap = CAP_DONE;
              done = 1'b1;
            end
          end
          if (done) begin
            r.report_valid = 1'b1;
            r.distance_cm = DistW'(echo_cnt / TicksPerCm);
            r.angle_deg = AngOutW'(angle);
          end else if (timer + 1 >= min1(timeout_len)) begin
            r.report_valid = 1'b1;
            r.angle_deg = AngTimeout;
            r.timed_out = 1'b1;
          end else begin
            timer++;
          end
          if (r.report_valid) begin
            phase = PH_GAP;
            timer = DelayW'(min1(gap_len) - 1);
            reports++;
          end
        end
        PH_GAP: begin
          if (timer > 0) timer--;
          else phase = PH_DECIDE;
        end
        default: begin
          if (angle >= angle_lim) begin
            angle = angle_lim;
            sweep_down = 1'b1;
          end else if (angle == 0) begin
            sweep_down = 1'b0;
          end
          steps_left = steps_per_move;
          timer = '0;
          phase = PH_STEP;
        end
      endcase
      tick_outputs.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void match_output(result_t got);
      result_t want;
      if (tick_outputs.size() == 0) begin
        errors++;
        $display("%0t: output transfer with no tick pending, actual %h", $time, got);
        return;
      end
      want = tick_outputs.pop_front();
      check_field("coil_pattern", want.coil_pattern, got.coil_pattern);
      check_field("trigger_out", want.trigger_out, got.trigger_out);
      check_field("report_valid", want.report_valid, got.report_valid);
      check_field("distance_cm", want.distance_cm, got.distance_cm);
      check_field("angle_deg", want.angle_deg, got.angle_deg);
      check_field("timed_out", want.timed_out, got.timed_out);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ussr_in_if  in_ch();
  ussr_out_if out_ch();

  ultrasonic_sweep_ranger DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  sweep_ledger ledger;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  bit          in_measure;
  bit          long_pulse;
  int unsigned meas_tick;
  int unsigned rise_at;
  int unsigned pulse_len;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("watchdog expired at %0t", $time);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.match_output({out_ch.coil_pattern, out_ch.trigger_out, out_ch.report_valid,
                           out_ch.distance_cm, out_ch.angle_deg, out_ch.timed_out});
  end

  // receiver: runs of always-ready, random stalls and a fixed 3-off/2-on pattern
  initial begin
    int unsigned mode;
    int unsigned left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ((left % 5) < 2);
        default: out_ch.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // shapes the echo pin from the predicted phase: at most one pulse per measurement, noise elsewhere
  function automatic logic next_echo();
    logic level;
    if (ledger.phase == PH_MEASURE) begin
      if (!in_measure) begin
        in_measure = 1'b1;
        meas_tick = 0;
        rise_at = $urandom_range(0, 5);
        if (long_pulse) begin
          rise_at = 2;
          pulse_len = TicksPerCm;
          long_pulse = 1'b0;
        end else begin
          case ($urandom_range(0, 9))
            0:       pulse_len = 0;
            1:       pulse_len = 1_000_000;
            2, 3:    pulse_len = TicksPerCm * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
            default: pulse_len = $urandom_range(1, 12);
          endcase
        end
      end
      level = (meas_tick >= rise_at) && (meas_tick - rise_at < pulse_len);
      meas_tick++;
    end else begin
      in_measure = 1'b0;
      level = ($urandom_range(0, 7) == 0);
    end
    return level;
  endfunction

  task automatic send_tick(input logic echo_bit);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        in_ch.echo_level <= 1'($urandom_range(0, 1));
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.echo_level <= echo_bit;
    do @(posedge clk); while (!in_ch.ready);
    ledger.log_tick(echo_bit);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (ledger.tick_outputs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataW'(val);
    @(posedge clk);
    ledger.set_reg(idx, CfgDataW'(val));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned step, input int unsigned settle,
                           input int unsigned trig, input int unsigned tmo,
                           input int unsigned gap, input int unsigned steps,
                           input int unsigned inc, input int unsigned lim);
    drain();
    write_reg(CFG_STEP_DELAY, step);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_TRIGGER, trig);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_STEPS, steps);
    write_reg(CFG_ANGLE_INC, inc);
    write_reg(CFG_ANGLE_LIM, lim);
  endtask

  task automatic run_ticks(input int unsigned min_ticks, input int unsigned min_reports);
    int unsigned sent;
    int unsigned first_report;
    sent = 0;
    first_report = ledger.reports;
    while (sent < min_ticks || ledger.reports - first_report < min_reports) begin
      // now and then hold off until every owed output has come back
      if ($urandom_range(0, 299) == 0) drain();
      send_tick(next_echo());
      sent++;
    end
  endtask

  initial begin
    ledger = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_STEP_DELAY;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.echo_level = 1'b0;
    burst_left = 0;
    in_measure = 1'b0;
    long_pulse = 1'b0;
    meas_tick = 0;
    rise_at = 0;
    pulse_len = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one decide tick at reset settings loads the default step count
    run_ticks(1, 0);

    // zero durations and steps, junk above the register widths
    configure(0, 0, 0, (5 << TimeoutW), 0, 0, (13'h1a5 << IncW) | 5, (10'h2b3 << AngleW) | 360);
    run_ticks(30, 4);
    // sweep up into the 1023 ceiling with the longest trigger
    configure(1, 1, 1023, 3, 1, 1, 90, 1023);
    run_ticks(60, 13);
    // sweep down past zero
    configure(2, 1, 3, 12, 2, 2, 90, 100);
    run_ticks(40, 4);
    // zero limit and lowest timeout values
    configure(1, 3, 2, 1, 1, 1, 7, 0);
    run_ticks(30, 3);

    repeat (2) begin
      configure($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 8),
                $urandom_range(0, 30), $urandom_range(0, 5), $urandom_range(0, 6),
                $urandom_range(0, 90), $urandom_range(0, 1023));
      run_ticks(40, 2);
    end

    // echo of exactly one centimeter inside a wider timeout window
    long_pulse = 1'b1;
    configure(1, 1, 20, 150, 2, 2, 3, 200);
    run_ticks(10, 2);

    configure(20'hFFFFF, 20'hFFFFF, 1023, 1, 20'hFFFFF, 4095, 90, 1023);
    run_ticks(30, 0);

    drain();
    if (ledger.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
